// ===== rtl/i2cmws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmws_pkg
// Shared types, codes and the microcode table of the I2C write sequencer.
// ----------------------------------------------------------------------------
package i2cmws_pkg;

    localparam int LIMIT_W = 20;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd1000000;
    localparam logic [7:0] ADDR_MAX = 8'h7F;

    // request types
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_BEGIN  = 2'd1;
    localparam logic [1:0] REQ_SAMPLE = 2'd2;

    // steps of the program
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_BUS   = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_ADDR  = 3'd3;
    localparam logic [2:0] ST_TXE   = 3'd4;
    localparam logic [2:0] ST_BTF   = 3'd5;

    // bus actions
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_CLEAR   = 3'd1;
    localparam logic [2:0] ACT_START   = 3'd2;
    localparam logic [2:0] ACT_WRITE   = 3'd3;
    localparam logic [2:0] ACT_CLRADDR = 3'd4;
    localparam logic [2:0] ACT_STOP    = 3'd5;

    // completion codes
    localparam logic [1:0] RC_OK      = 2'd0;
    localparam logic [1:0] RC_NACK    = 2'd1;
    localparam logic [1:0] RC_BUSERR  = 2'd2;
    localparam logic [1:0] RC_TIMEOUT = 2'd3;

    // wait conditions
    localparam logic [2:0] COND_BUS_FREE = 3'd0;
    localparam logic [2:0] COND_SB       = 3'd1;
    localparam logic [2:0] COND_ADDR     = 3'd2;
    localparam logic [2:0] COND_TXE      = 3'd3;
    localparam logic [2:0] COND_BTF      = 3'd4;

    // data sources
    localparam logic [1:0] SRC_ZERO  = 2'd0;
    localparam logic [1:0] SRC_ADDR  = 2'd1;
    localparam logic [1:0] SRC_STORE = 2'd2;

    localparam int ERR_ACK_BIT = 2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] dev_address;
        logic [8:0] byte_count;
        logic [7:0] data_byte;
        logic       flag_start_sent;
        logic       flag_address_sent;
        logic       flag_tx_empty;
        logic       flag_transfer_done;
        logic       flag_bus_busy;
        logic [3:0] error_flags;
    } item_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_value;
        logic       last_of_run;
        logic       done_res;
        logic [1:0] result_code;
    } res_t;

    typedef struct packed {
        logic push0;
        logic push1;
        res_t res0;
        res_t res1;
    } push_t;

    typedef struct packed {
        logic [2:0] cond;
        logic       chk_err;
        logic [2:0] act;
        logic [1:0] src;
        logic       clr_idx;
        logic       loop;
        logic       fin;
        logic [2:0] nxt;
    } ctl_word_t;

    function automatic ctl_word_t cw_rom(input logic [2:0] step);
        ctl_word_t cw;
        cw = '{COND_BUS_FREE, 1'b0, ACT_NONE, SRC_ZERO, 1'b0, 1'b0, 1'b0, ST_IDLE};
        case (step)
            ST_BUS:   cw = '{COND_BUS_FREE, 1'b0, ACT_START,   SRC_ZERO,
                             1'b0, 1'b0, 1'b0, ST_START};
            ST_START: cw = '{COND_SB,       1'b1, ACT_WRITE,   SRC_ADDR,
                             1'b0, 1'b0, 1'b0, ST_ADDR};
            ST_ADDR:  cw = '{COND_ADDR,     1'b1, ACT_CLRADDR, SRC_ZERO,
                             1'b1, 1'b0, 1'b0, ST_TXE};
            ST_TXE:   cw = '{COND_TXE,      1'b1, ACT_WRITE,   SRC_STORE,
                             1'b0, 1'b1, 1'b0, ST_BTF};
            ST_BTF:   cw = '{COND_BTF,      1'b1, ACT_STOP,    SRC_ZERO,
                             1'b0, 1'b0, 1'b1, ST_IDLE};
            default:  cw = '{COND_BUS_FREE, 1'b0, ACT_NONE,    SRC_ZERO,
                             1'b0, 1'b0, 1'b0, ST_IDLE};
        endcase
        return cw;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/i2cmws_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmws_store
// Payload byte memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module i2cmws_store #(
    parameter int MAX_PAYLOAD = 256,
    parameter int AW          = 8
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [0:MAX_PAYLOAD-1];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== rtl/i2cmws_out_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmws_out_queue
// Four-word result queue, up to two words pushed per cycle.
// ----------------------------------------------------------------------------
module i2cmws_out_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire i2cmws_pkg::push_t push,
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output i2cmws_pkg::res_t       head
);
    import i2cmws_pkg::*;

    res_t       mem [0:3];
    logic [1:0] head_reg, head_next;
    logic [1:0] tail_reg, tail_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 3'd0);
    assign pop       = out_valid && !out_stall;
    assign room      = (count_reg <= 3'd2);
    assign head      = mem[head_reg];

    always_comb
    begin
        head_next  = head_reg + 2'(pop);
        tail_next  = tail_reg + 2'(push.push0) + 2'(push.push1);
        count_next = count_reg + 3'(push.push0) + 3'(push.push1) - 3'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            mem[tail_reg] <= push.res0;
        end
        if (push.push1)
        begin
            mem[tail_reg + 2'd1] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("result queue overflow");

    a_tail_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_reg - head_reg) == count_reg[1:0])
        else $error("queue pointers disagree with count");

    a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.push1 |-> push.push0)
        else $error("second word pushed without first");

endmodule
`default_nettype wire

// ===== rtl/i2cmws_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmws_seq
// Step counter, microcode decode and datapath of the write sequencer.
// ----------------------------------------------------------------------------
module i2cmws_seq #(
    parameter int MAX_PAYLOAD = 256,
    parameter int PTR_W       = 9,
    parameter int AW          = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write_en,
    input  wire logic [19:0]           cfg_write_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire i2cmws_pkg::item_t     item,
    input  wire logic                  q_room,
    output i2cmws_pkg::push_t          push,
    output logic                       st_we,
    output logic [AW-1:0]              st_waddr,
    output logic [7:0]                 st_wdata,
    output logic [AW-1:0]              st_raddr,
    input  wire logic [7:0]            st_rdata
);
    import i2cmws_pkg::*;

    item_t              item_reg;
    logic               pend_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [2:0]         step_reg, step_next;
    logic [LIMIT_W-1:0] wc_reg, wc_next;
    logic [PTR_W-1:0]   lptr_reg, lptr_next;
    logic [PTR_W-1:0]   sidx_reg, sidx_next;
    logic [PTR_W-1:0]   slen_reg, slen_next;
    logic [6:0]         taddr_reg, taddr_next;

    ctl_word_t          cw;
    logic               cond_ok;
    logic [LIMIT_W-1:0] lim_eff;
    logic [LIMIT_W-1:0] wc_inc;
    logic [PTR_W-1:0]   sidx_inc;
    logic [31:0]        cnt_ext;
    logic [31:0]        cnt_clip;
    logic [7:0]         dval;
    logic               accept;

    assign in_stall = pend_reg || !q_room;
    assign accept   = in_valid && !in_stall;
    assign st_raddr = sidx_reg[AW-1:0];

    assign cw       = cw_rom(step_reg);
    assign lim_eff  = (limit_reg == '0) ? LIMIT_W'(1) : limit_reg;
    assign wc_inc   = wc_reg + LIMIT_W'(1);
    assign sidx_inc = sidx_reg + PTR_W'(1);
    assign cnt_ext  = 32'(item_reg.byte_count);
    assign cnt_clip = (cnt_ext > 32'(MAX_PAYLOAD)) ? 32'(MAX_PAYLOAD) : cnt_ext;

    always_comb
    begin
        case (cw.cond)
            COND_BUS_FREE: cond_ok = !item_reg.flag_bus_busy;
            COND_SB:       cond_ok = item_reg.flag_start_sent;
            COND_ADDR:     cond_ok = item_reg.flag_address_sent;
            COND_TXE:      cond_ok = item_reg.flag_tx_empty;
            COND_BTF:      cond_ok = item_reg.flag_transfer_done;
            default:       cond_ok = 1'b0;
        endcase
        case (cw.src)
            SRC_ADDR:  dval = {taddr_reg, 1'b0};
            SRC_STORE: dval = st_rdata;
            default:   dval = 8'd0;
        endcase
    end

    always_comb
    begin
        step_next  = step_reg;
        wc_next    = wc_reg;
        lptr_next  = lptr_reg;
        sidx_next  = sidx_reg;
        slen_next  = slen_reg;
        taddr_next = taddr_reg;
        push       = '0;
        st_we      = 1'b0;
        st_waddr   = lptr_reg[AW-1:0];
        st_wdata   = item_reg.data_byte;

        if (pend_reg)
        begin
            case (item_reg.req_type)
                REQ_LOAD:
                begin
                    if (lptr_reg < PTR_W'(MAX_PAYLOAD))
                    begin
                        st_we     = 1'b1;
                        lptr_next = lptr_reg + PTR_W'(1);
                    end
                end
                REQ_BEGIN:
                begin
                    if (step_reg == ST_IDLE)
                    begin
                        lptr_next  = '0;
                        push.push0 = 1'b1;
                        if (item_reg.dev_address > ADDR_MAX
                            || item_reg.byte_count == 9'd0)
                        begin
                            push.res0 = '{ACT_NONE, 8'd0, 1'b1, 1'b1, RC_BUSERR};
                        end
                        else
                        begin
                            taddr_next = item_reg.dev_address[6:0];
                            slen_next  = cnt_clip[PTR_W-1:0];
                            sidx_next  = '0;
                            wc_next    = '0;
                            step_next  = ST_BUS;
                            push.res0  = '{ACT_CLEAR, 8'd0, 1'b1, 1'b0, RC_OK};
                        end
                    end
                end
                REQ_SAMPLE:
                begin
                    if (step_reg != ST_IDLE)
                    begin
                        if (cond_ok)
                        begin
                            wc_next    = '0;
                            push.push0 = 1'b1;
                            push.res0  = '{cw.act, dval, 1'b1, cw.fin, RC_OK};
                            step_next  = cw.nxt;
                            if (cw.clr_idx)
                            begin
                                sidx_next = '0;
                            end
                            if (cw.loop)
                            begin
                                sidx_next = sidx_inc;
                                if (sidx_inc < slen_reg)
                                begin
                                    step_next = step_reg;
                                end
                            end
                        end
                        else
                        begin
                            push.res0 = '{ACT_STOP, 8'd0, 1'b0, 1'b0, RC_OK};
                            push.res1 = '{ACT_CLEAR, 8'd0, 1'b1, 1'b1, RC_TIMEOUT};
                            if (cw.chk_err && item_reg.error_flags[ERR_ACK_BIT])
                            begin
                                push.res1.result_code = RC_NACK;
                                push.push0 = 1'b1;
                                push.push1 = 1'b1;
                            end
                            else if (cw.chk_err && item_reg.error_flags != 4'd0)
                            begin
                                push.res1.result_code = RC_BUSERR;
                                push.push0 = 1'b1;
                                push.push1 = 1'b1;
                            end
                            else if (wc_inc >= lim_eff)
                            begin
                                push.push0 = 1'b1;
                                push.push1 = 1'b1;
                            end
                            if (push.push1)
                            begin
                                step_next = ST_IDLE;
                                wc_next   = '0;
                            end
                            else
                            begin
                                wc_next = wc_inc;
                            end
                        end
                    end
                end
                default:
                begin
                    step_next = step_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            limit_reg <= LIMIT_RESET;
            step_reg  <= ST_IDLE;
            wc_reg    <= '0;
            lptr_reg  <= '0;
            sidx_reg  <= '0;
            slen_reg  <= '0;
            taddr_reg <= '0;
        end
        else
        begin
            pend_reg  <= accept;
            if (cfg_write_en)
            begin
                limit_reg <= cfg_write_data;
            end
            step_reg  <= step_next;
            wc_reg    <= wc_next;
            lptr_reg  <= lptr_next;
            sidx_reg  <= sidx_next;
            slen_reg  <= slen_next;
            taddr_reg <= taddr_next;
        end
    end

    a_txe_index: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ST_TXE) |-> (sidx_reg < slen_reg))
        else $error("send index past length in byte loop");

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lptr_reg <= PTR_W'(MAX_PAYLOAD))
        else $error("load pointer past store");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |=> !pend_reg)
        else $error("item accepted while previous one in work");

endmodule
`default_nettype wire

// ===== rtl/i2c_master_write_sequencer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_write_sequencer_core
// Polled I2C master write sequencer driven by a microcode table.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one word per item: load byte,
// begin transfer or status sample. Output channel (out_valid / out_stall)
// carries register commands, at most two words per input word.
// An accepted word is processed in the following cycle; its result words
// enter a four-word queue at the end of that cycle and leave it in order.
// No new input word is taken while the input register still holds the
// previous one for its decode in the step sequencer.
// in_stall is also raised while the queue holds more than two words, so a
// stalled receiver backs up into the input channel without losing words.
// cfg_write_en / cfg_write_data set the wait limit; write only while idle.
// Reset puts the sequencer idle, the wait limit to 1000000 and empties the
// queue; the payload memory is not cleared.
// ----------------------------------------------------------------------------
module i2c_master_write_sequencer_core #(
    parameter int MAX_PAYLOAD = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic [19:0] cfg_write_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  dev_address,
    input  wire logic [8:0]  byte_count,
    input  wire logic [7:0]  data_byte,
    input  wire logic        flag_start_sent,
    input  wire logic        flag_address_sent,
    input  wire logic        flag_tx_empty,
    input  wire logic        flag_transfer_done,
    input  wire logic        flag_bus_busy,
    input  wire logic [3:0]  error_flags,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       action,
    output logic [7:0]       data_value,
    output logic             last_of_run,
    output logic             done_res,
    output logic [1:0]       result_code
);
    import i2cmws_pkg::*;

    localparam int PTR_W = $clog2(MAX_PAYLOAD + 1);
    localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    item_t         item;
    push_t         push;
    res_t          head;
    logic          q_room;
    logic          st_we;
    logic [AW-1:0] st_waddr;
    logic [7:0]    st_wdata;
    logic [AW-1:0] st_raddr;
    logic [7:0]    st_rdata;

    assign item = '{req_type, dev_address, byte_count, data_byte,
                    flag_start_sent, flag_address_sent, flag_tx_empty,
                    flag_transfer_done, flag_bus_busy, error_flags};

    i2cmws_seq #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .PTR_W       (PTR_W),
        .AW          (AW)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .item           (item),
        .q_room         (q_room),
        .push           (push),
        .st_we          (st_we),
        .st_waddr       (st_waddr),
        .st_wdata       (st_wdata),
        .st_raddr       (st_raddr),
        .st_rdata       (st_rdata)
    );

    i2cmws_store #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    i2cmws_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (q_room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign action      = head.action;
    assign data_value  = head.data_value;
    assign last_of_run = head.last_of_run;
    assign done_res    = head.done_res;
    assign result_code = head.result_code;

endmodule
`default_nettype wire
